[design/arq_sw_pkg.sv]
// arq_sw_pkg: shared types and constants of the arq send window
// request/result payloads, slot record, scan accumulator, command and status codes
// no dependencies
package arq_sw_pkg;

  localparam int unsigned SLOTS_DEF = 4;
  localparam logic [15:0] RETRY_RESET = 16'd2;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_ACK      = 2'd1,
    CMD_SEND     = 2'd2,
    CMD_RENUMBER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_ACKED  = 2'd1,
    ST_ACTIVE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [31:0]        now;
    logic [4:0]         msg_kind;
    logic [31:0]        acked_seq;
    logic signed [31:0] seq_shift;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  slot;
    logic [31:0] seq;
    logic [4:0]  kind_out;
    logic        window_empty;
  } rsp_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] due;
    logic [15:0] retry;
    logic [4:0]  kind;
  } rec_t;

  typedef struct packed {
    logic        found;
    logic        full;
    logic [31:0] best_age;
    logic [31:0] best_seq;
    logic [15:0] best_wait;
    logic [4:0]  best_kind;
  } scan_acc_t;

endpackage

[design/arq_sw_ram.sv]
// arq_sw_ram: generic single-write, single-read ram with registered read data
// holds the per-slot records; no package dependency
module arq_sw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/arq_sw_scan.sv]
// arq_sw_scan: shared compare unit, folds one slot record into the scan accumulator
// depends on arq_sw_pkg
module arq_sw_scan #(
  parameter int unsigned SLOTS = arq_sw_pkg::SLOTS_DEF
) (
  input  arq_sw_pkg::req_t                 req,
  input  logic [31:0]                      next_seq,
  input  arq_sw_pkg::status_t              status,
  input  arq_sw_pkg::rec_t                 rec,
  input  logic [$clog2(SLOTS)-1:0]         idx,
  input  arq_sw_pkg::scan_acc_t            acc_in,
  input  logic [$clog2(SLOTS)-1:0]         pick_in,
  output arq_sw_pkg::scan_acc_t            acc_out,
  output logic [$clog2(SLOTS)-1:0]         pick_out,
  output logic                             wr_en,
  output arq_sw_pkg::rec_t                 wr_rec
);
  import arq_sw_pkg::*;

  logic [31:0] age;
  logic [31:0] seq_diff;

  assign age = next_seq - rec.seq;
  assign seq_diff = rec.seq - acc_in.best_seq;

  always_comb begin
    acc_out  = acc_in;
    pick_out = pick_in;
    wr_en    = 1'b0;
    wr_rec   = rec;
    case (req.cmd)
      CMD_ENQUEUE: begin
        if (status == ST_ACTIVE) begin
          if (age == 32'(SLOTS)) begin
            acc_out.full = 1'b1;
          end
        end else if (status == ST_ACKED) begin
          // freshest acked slot, last one wins a tie
          if (age <= acc_in.best_age) begin
            pick_out         = idx;
            acc_out.found    = 1'b1;
            acc_out.best_age = age;
          end
        end else if (status == ST_FREE && !acc_in.found) begin
          pick_out      = idx;
          acc_out.found = 1'b1;
        end
      end
      CMD_ACK: begin
        if (!acc_in.found && status == ST_ACTIVE && rec.seq == req.acked_seq) begin
          pick_out         = idx;
          acc_out.found    = 1'b1;
          acc_out.best_seq = rec.seq;
        end
      end
      CMD_SEND: begin
        // oldest due slot, sequence compare modulo 2^32
        if (status == ST_ACTIVE && req.now >= rec.due &&
            (!acc_in.found || seq_diff >= HALF_RANGE)) begin
          pick_out          = idx;
          acc_out.found     = 1'b1;
          acc_out.best_seq  = rec.seq;
          acc_out.best_wait = rec.retry;
          acc_out.best_kind = rec.kind;
        end
      end
      CMD_RENUMBER: begin
        if (status == ST_ACTIVE) begin
          wr_en      = 1'b1;
          wr_rec.seq = rec.seq + $unsigned(req.seq_shift);
          wr_rec.due = req.now;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

endmodule

[design/arq_send_window_core.sv]
// arq_send_window_core: retransmit window of a reliable layer, one slot scanned per cycle
// one request at a time: a new request is taken only once the result has been taken, as the
//   scan steps slot by slot through the record ram read port and the shared compare unit
// reset (rst, synchronous): all slots free, next_seq 0, retry_interval 2, no result pending
// depends on arq_sw_pkg, arq_sw_ram, arq_sw_scan
module arq_send_window_core #(
  parameter int unsigned SLOTS = arq_sw_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  arq_sw_pkg::req_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output arq_sw_pkg::rsp_t  rsp,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import arq_sw_pkg::*;

  localparam int unsigned IDXW = $clog2(SLOTS);
  localparam int unsigned CNTW = $clog2(SLOTS + 1);
  localparam int unsigned RECW = $bits(rec_t);

  state_t          state;
  state_t          state_next;
  logic [CNTW-1:0] cnt;
  req_t            req_q;
  scan_acc_t       acc;
  scan_acc_t       acc_next;
  logic [IDXW-1:0] pick;
  logic [IDXW-1:0] pick_next;
  logic [31:0]     next_seq;
  logic [31:0]     next_seq_next;
  logic [15:0]     retry_interval;
  status_t         status      [SLOTS];
  status_t         status_next [SLOTS];
  rsp_t            rsp_next;

  logic            accept;
  logic            evaluating;
  logic [CNTW-1:0] cnt_dec;
  logic [IDXW-1:0] eidx;
  logic [IDXW-1:0] raddr;
  logic [RECW-1:0] rdata;
  rec_t            rec;
  logic            we;
  logic [IDXW-1:0] waddr;
  rec_t            wrec;
  logic            scan_we;
  rec_t            scan_wrec;
  logic            any_active;

  assign accept     = req_valid && !req_stall;
  assign evaluating = (state == S_SCAN) && (cnt != '0);
  assign cnt_dec    = cnt - CNTW'(1);
  assign eidx       = cnt_dec[IDXW-1:0];
  assign raddr      = (cnt < CNTW'(SLOTS)) ? cnt[IDXW-1:0] : '0;
  assign rec        = rec_t'(rdata);

  arq_sw_ram #(
    .WIDTH(RECW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(RECW'(wrec)),
    .raddr(raddr),
    .rdata(rdata)
  );

  arq_sw_scan #(
    .SLOTS(SLOTS)
  ) u_scan (
    .req     (req_q),
    .next_seq(next_seq),
    .status  (status[eidx]),
    .rec     (rec),
    .idx     (eidx),
    .acc_in  (acc),
    .pick_in (pick),
    .acc_out (acc_next),
    .pick_out(pick_next),
    .wr_en   (scan_we),
    .wr_rec  (scan_wrec)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (cnt == CNTW'(SLOTS)) state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!rsp_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    req_stall = (state != S_IDLE);
    rsp_valid = (state == S_OUT);
  end

  // write-back of renumbered slots during the scan, final update of the chosen slot and the result
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      status_next[i] = status[i];
    end
    next_seq_next = next_seq;
    we            = 1'b0;
    waddr         = eidx;
    wrec          = scan_wrec;
    rsp_next      = '0;
    if (evaluating && scan_we) begin
      we = 1'b1;
    end
    if (state == S_FINISH) begin
      case (req_q.cmd)
        CMD_ENQUEUE: begin
          if (!acc.full && acc.found) begin
            we                = 1'b1;
            waddr             = pick;
            wrec.seq          = next_seq;
            wrec.due          = '0;
            wrec.retry        = retry_interval;
            wrec.kind         = req_q.msg_kind;
            status_next[pick] = ST_ACTIVE;
            next_seq_next     = next_seq + 32'd1;
            rsp_next.ok       = 1'b1;
            rsp_next.slot     = 2'(pick);
            rsp_next.seq      = next_seq;
          end
        end
        CMD_ACK: begin
          if (acc.found) begin
            status_next[pick] = ST_ACKED;
            rsp_next.ok       = 1'b1;
            rsp_next.slot     = 2'(pick);
            rsp_next.seq      = acc.best_seq;
          end
        end
        CMD_SEND: begin
          if (acc.found) begin
            we                = 1'b1;
            waddr             = pick;
            wrec.seq          = acc.best_seq;
            wrec.due          = req_q.now + 32'(acc.best_wait);
            wrec.retry        = acc.best_wait;
            wrec.kind         = acc.best_kind;
            rsp_next.ok       = 1'b1;
            rsp_next.slot     = 2'(pick);
            rsp_next.seq      = acc.best_seq;
            rsp_next.kind_out = acc.best_kind;
          end
        end
        CMD_RENUMBER: begin
          next_seq_next = next_seq + $unsigned(req_q.seq_shift);
          rsp_next.ok   = 1'b1;
          rsp_next.seq  = next_seq_next;
        end
        default: begin
          rsp_next = '0;
        end
      endcase
    end
    any_active = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      any_active = any_active | (status_next[i] == ST_ACTIVE);
    end
    rsp_next.window_empty = !any_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      next_seq       <= '0;
      retry_interval <= RETRY_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        status[i] <= ST_FREE;
      end
    end else begin
      state    <= state_next;
      next_seq <= next_seq_next;
      for (int i = 0; i < SLOTS; i++) begin
        status[i] <= status_next[i];
      end
      if (cfg_we) begin
        retry_interval <= cfg_wdata;
      end
      if (accept) begin
        cnt <= '0;
      end else if (state == S_SCAN) begin
        cnt <= cnt + CNTW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      pick  <= '0;
      acc   <= '{best_age: 32'(SLOTS), default: '0};
    end else if (evaluating) begin
      acc  <= acc_next;
      pick <= pick_next;
    end
    if (state == S_FINISH) begin
      rsp <= rsp_next;
    end
  end

endmodule

[design/arq_sw_checker.sv]
// arq_sw_checker: port-level assertions for arq_send_window_core
// depends on arq_sw_pkg; bound to the top level below
module arq_sw_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_stall,
  input logic             rsp_valid,
  input logic             rsp_stall,
  input arq_sw_pkg::rsp_t rsp
);
  import arq_sw_pkg::*;

  // one request in flight: no new request while a result waits
  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall && !rsp_valid)
    else $error("block not busy after request");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // refused or unmatched results carry zeros
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ok) |-> (rsp.slot == 2'd0 && rsp.seq == 32'd0 &&
                                rsp.kind_out == 5'd0))
    else $error("refused result carries data");

endmodule

bind arq_send_window_core arq_sw_checker u_arq_sw_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);
